FILE: src/bd3_pkg.sv
// Shared types, constants and helpers for the 3x3 binary dilation block.
// No dependencies; every other file of the block imports this package.
package bd3_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int DIM_W      = 11;
  localparam int OUT_POS_W  = 10;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 11'd480;

  // Request kinds: a pixel of the frame or a flush request after it.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] pixel_blue;
    logic [7:0] pixel_green;
    logic [7:0] pixel_red;
  } in_item_t;

  typedef struct packed {
    logic                 foreground;
    logic [OUT_POS_W-1:0] out_row;
    logic [OUT_POS_W-1:0] out_col;
    logic                 last_of_frame;
  } out_item_t;

  // Per-request position info handed from the scan stage to the window stage.
  typedef struct packed {
    logic                 flag;
    logic                 emit;
    logic                 last;
    logic                 keep_up;
    logic                 keep_down;
    logic                 keep_left;
    logic                 keep_right;
    logic [OUT_POS_W-1:0] out_row;
    logic [OUT_POS_W-1:0] out_col;
  } pos_t;

  // Zero counts as one, anything above the maximum counts as the maximum.
  function automatic int clamp_dim(logic [DIM_W-1:0] v, int maxv);
    int r;
    r = int'(v);
    if (r < 1) r = 1;
    if (r > maxv) r = maxv;
    return r;
  endfunction

endpackage

FILE: src/binary_dilation_3x3.sv
// 3x3 binary dilation of a streamed RGB mask. One request per cycle unless the
// result side stalls. Each result passes stage one, then the result register;
// the stream lag is image_width+1 requests (one row plus one pixel).
// Reset clears counters, window and valids and sets width 640, height 480; line
// stores are not cleared, as stale entries only feed masked rows.
module binary_dilation_3x3 import bd3_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int RowW = $clog2(MAX_HEIGHT + 2);

  logic [DIM_W-1:0] image_width_q, image_width_d;
  logic [DIM_W-1:0] image_height_q, image_height_d;
  logic             cfg_wr;
  cfg_reg_e         cfg_sel;
  logic [WW-1:0]    w_eff;
  logic [RowW-1:0]  h_eff;

  logic             in_acc;
  logic             s1_adv;
  logic             s1_valid;
  pos_t             s1_pos;
  logic [ColW-1:0]  rd_addr;
  logic [ColW-1:0]  s1_addr;
  logic             older;
  logic             newer;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[2]);

  always_comb begin
    image_width_d  = image_width_q;
    image_height_d = image_height_q;
    prdata         = '0;
    case (cfg_sel)
      REG_IMAGE_WIDTH: begin
        prdata = APB_DATA_W'(image_width_q);
        if (cfg_wr) image_width_d = pwdata[DIM_W-1:0];
      end
      REG_IMAGE_HEIGHT: begin
        prdata = APB_DATA_W'(image_height_q);
        if (cfg_wr) image_height_d = pwdata[DIM_W-1:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= IMAGE_WIDTH_RST;
      image_height_q <= IMAGE_HEIGHT_RST;
    end else begin
      image_width_q  <= image_width_d;
      image_height_q <= image_height_d;
    end
  end

  assign w_eff = WW'(clamp_dim(image_width_q, MAX_WIDTH));
  assign h_eff = RowW'(clamp_dim(image_height_q, MAX_HEIGHT));

  // A request without a result moves on even when the result side stalls.
  assign s1_adv     = s1_valid && (!s1_pos.emit || !out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  bd3_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_acc_i    (in_acc),
    .s1_adv_i    (s1_adv),
    .cfg_clear_i (cfg_wr),
    .in_data_i   (in_data_i),
    .w_eff_i     (w_eff),
    .h_eff_i     (h_eff),
    .rd_addr_o   (rd_addr),
    .s1_valid_o  (s1_valid),
    .s1_pos_o    (s1_pos),
    .s1_addr_o   (s1_addr)
  );

  bd3_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_acc_i  (in_acc),
    .rd_addr_i (rd_addr),
    .s1_adv_i  (s1_adv),
    .wr_addr_i (s1_addr),
    .flag_i    (s1_pos.flag),
    .older_o   (older),
    .newer_o   (newer)
  );

  bd3_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_adv_i    (s1_adv),
    .cfg_clear_i (cfg_wr),
    .s1_pos_i    (s1_pos),
    .older_i     (older),
    .newer_i     (newer),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  a_last_at_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_of_frame |->
      (out_data_o.out_col == OUT_POS_W'(w_eff - WW'(1))))
    else $error("last pixel of the frame not at the end of a row");

endmodule

FILE: src/bd3_scan.sv
// Input position counters and output position decode, plus the stage-one register.
// Depends on bd3_pkg.
module bd3_scan import bd3_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int ColW = $clog2(MAX_WIDTH),
  localparam int WW   = $clog2(MAX_WIDTH + 1),
  localparam int RowW = $clog2(MAX_HEIGHT + 2)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_acc_i,
  input  logic            s1_adv_i,
  input  logic            cfg_clear_i,
  input  in_item_t        in_data_i,
  input  logic [WW-1:0]   w_eff_i,
  input  logic [RowW-1:0] h_eff_i,
  output logic [ColW-1:0] rd_addr_o,
  output logic            s1_valid_o,
  output pos_t            s1_pos_o,
  output logic [ColW-1:0] s1_addr_o
);

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            s1_valid_q, s1_valid_d;
  pos_t            pos_q, pos_d;
  logic [ColW-1:0] addr_q;

  logic            col_ge1;
  logic [RowW-1:0] orow;
  logic [WW-1:0]   ocol;
  logic            col_end;

  always_comb begin
    col_ge1 = (col_q != '0);
    orow    = col_ge1 ? (row_q - RowW'(1)) : (row_q - RowW'(2));
    ocol    = col_ge1 ? (WW'(col_q) - WW'(1)) : (w_eff_i - WW'(1));
    col_end = (WW'(col_q) >= (w_eff_i - WW'(1)));

    pos_d.flag       = (in_data_i.kind == KIND_PIXEL) &&
                       ((in_data_i.pixel_blue | in_data_i.pixel_green |
                         in_data_i.pixel_red) != 8'd0);
    // A result is due once a full row plus one pixel has been taken.
    pos_d.emit       = (row_q >= RowW'(2)) || ((row_q == RowW'(1)) && col_ge1);
    pos_d.last       = pos_d.emit && (orow == (h_eff_i - RowW'(1))) &&
                       (ocol == (w_eff_i - WW'(1)));
    pos_d.keep_up    = (orow != '0);
    pos_d.keep_down  = (orow < (h_eff_i - RowW'(1)));
    pos_d.keep_left  = (ocol != '0);
    pos_d.keep_right = (ocol < (w_eff_i - WW'(1)));
    pos_d.out_row    = OUT_POS_W'(orow);
    pos_d.out_col    = OUT_POS_W'(ocol);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_clear_i) begin
      col_d = '0;
      row_d = '0;
    end else if (in_acc_i) begin
      if (pos_d.last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_end) begin
        col_d = '0;
        // The row count stops at h_eff+1, inside the flush rows.
        if (row_q < (h_eff_i + RowW'(1))) row_d = row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc_i) begin
      pos_q  <= pos_d;
      addr_q <= col_q;
    end
  end

  assign rd_addr_o  = col_q;
  assign s1_valid_o = s1_valid_q;
  assign s1_pos_o   = pos_q;
  assign s1_addr_o  = addr_q;

  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc_i && pos_d.last |=> (col_q == '0) && (row_q == '0))
    else $error("position counters did not restart after the last pixel");

  a_row_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= (h_eff_i + RowW'(1)))
    else $error("row count ran past the flush rows");

endmodule

FILE: src/bd3_line_store.sv
// Two one-bit line stores packed as one 2-bit wide memory with a registered read.
// Depends on bd3_pkg. Entries never cleared: stale rows are masked downstream.
module bd3_line_store import bd3_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int ColW = $clog2(MAX_WIDTH)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_acc_i,
  input  logic [ColW-1:0] rd_addr_i,
  input  logic            s1_adv_i,
  input  logic [ColW-1:0] wr_addr_i,
  input  logic            flag_i,
  output logic            older_o,
  output logic            newer_o
);

  // Bit 1 holds the flag two rows back, bit 0 the flag one row back.
  logic [1:0] mem [MAX_WIDTH];
  logic [1:0] rd_q;
  logic [1:0] fwd_data_q;
  logic       fwd_q;
  logic [1:0] rd_eff;
  logic [1:0] wr_data;

  assign rd_eff  = fwd_q ? fwd_data_q : rd_q;
  assign wr_data = {rd_eff[0], flag_i};

  always_ff @(posedge clk_i) begin
    if (in_acc_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wr_data;
    end
    if (s1_adv_i) begin
      mem[wr_addr_i] <= wr_data;
    end
  end

  // With a one-pixel row the same entry is read while the previous request
  // writes it; that write is taken from the bypass instead.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_acc_i) begin
      fwd_q <= s1_adv_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign older_o = rd_eff[1];
  assign newer_o = rd_eff[0];

endmodule

FILE: src/bd3_window.sv
// 3x3 flag window, neighborhood OR with frame-edge masking, and the result register.
// Depends on bd3_pkg.
module bd3_window import bd3_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s1_adv_i,
  input  logic      cfg_clear_i,
  input  pos_t      s1_pos_i,
  input  logic      older_i,
  input  logic      newer_i,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output out_item_t out_data_o
);

  logic [8:0] win_q, win_d, win_new;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q;
  logic       acc;

  // Each 3-bit column holds rows two up, one up and current, from bit 0.
  always_comb begin
    logic [2:0] rmask;
    logic [2:0] cmask;
    win_new = {s1_pos_i.flag, newer_i, older_i, win_q[8:3]};
    rmask   = {s1_pos_i.keep_down, 1'b1, s1_pos_i.keep_up};
    cmask   = {s1_pos_i.keep_right, 1'b1, s1_pos_i.keep_left};
    acc     = 1'b0;
    for (int j = 0; j < 3; j++) begin
      if (cmask[j] && ((win_new[3*j +: 3] & rmask) != 3'b000)) acc = 1'b1;
    end
  end

  always_comb begin
    win_d = win_q;
    if (cfg_clear_i) begin
      win_d = '0;
    end else if (s1_adv_i) begin
      win_d = s1_pos_i.last ? 9'd0 : win_new;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv_i && s1_pos_i.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      win_q       <= win_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv_i && s1_pos_i.emit) begin
      out_q.foreground    <= acc;
      out_q.out_row       <= s1_pos_i.out_row;
      out_q.out_col       <= s1_pos_i.out_col;
      out_q.last_of_frame <= s1_pos_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv_i && s1_pos_i.emit |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

  a_window_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv_i && s1_pos_i.last |=> (win_q == 9'd0))
    else $error("window not cleared after the last pixel");

endmodule
